// ===== rtl/core/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants for the stability margin finder: datapath
// widths, angle and saturation limits, and the sequencer state type.
// ----------------------------------------------------------------------------
package smf_pkg;

  // crossing quantity width (magnitude or phase offset by a half turn)
  localparam int DIV_W = 21;
  // interpolation operand width (holds unsigned Q16.16 and signed differences)
  localparam int IW = 34;

  localparam int HALF_TURN = 46080;
  localparam int PHASE_MIN = -524288;
  localparam int PHASE_MAX = 524287;
  localparam int MAG_MIN   = -32768;
  localparam int MAG_MAX   = 32767;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TEST,
    S_NEXT,
    S_DIV_START,
    S_DIV_WAIT,
    S_F_START,
    S_F_WAIT,
    S_Y_START,
    S_Y_WAIT,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/core/smf_divider.sv =====
// ----------------------------------------------------------------------------
// smf_divider
// Serial restoring divider for the interpolation fraction. Returns
// floor(num * 2^FRACTION_BITS / den), one quotient bit per cycle, given
// num <= den; a zero divisor returns zero.
// ----------------------------------------------------------------------------
module smf_divider #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [smf_pkg::DIV_W-1:0]       num,
  input  logic [smf_pkg::DIV_W-1:0]       den,
  output logic                            done,
  output logic [FRACTION_BITS:0]          quot
);

  localparam int TW    = FRACTION_BITS + 1;
  localparam int CNT_W = $clog2(TW + 1);

  logic [smf_pkg::DIV_W:0]   rem;
  logic [smf_pkg::DIV_W-1:0] dreg;
  logic [TW-1:0]             q;
  logic [CNT_W-1:0]          cnt;
  logic                      running;
  logic                      den_zero;

  logic                      qbit;
  logic [smf_pkg::DIV_W:0]   trial;
  logic [smf_pkg::DIV_W:0]   rem_sel;

  always_comb begin
    trial   = rem - {1'b0, dreg};
    qbit    = rem >= {1'b0, dreg};
    rem_sel = qbit ? trial : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= {1'b0, num};
        dreg     <= den;
        den_zero <= den == '0;
        q        <= '0;
        cnt      <= CNT_W'(TW);
        running  <= 1'b1;
      end else if (running) begin
        q   <= {q[TW-2:0], qbit};
        rem <= {rem_sel[smf_pkg::DIV_W-1:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quot = den_zero ? '0 : q;

endmodule

// ===== rtl/core/smf_interp.sv =====
// ----------------------------------------------------------------------------
// smf_interp
// Three-stage linear interpolator: a0 + floor(t * (a1 - a0) / 2^FRACTION_BITS)
// with an unsigned Q1.FRACTION_BITS fraction t.
// ----------------------------------------------------------------------------
module smf_interp #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [smf_pkg::IW-1:0]    a0,
  input  logic signed [smf_pkg::IW-1:0]    a1,
  input  logic [FRACTION_BITS:0]           t,
  output logic                             done,
  output logic signed [smf_pkg::IW-1:0]    result
);

  localparam int TW = FRACTION_BITS + 1;
  localparam int PW = smf_pkg::IW + TW + 1;

  logic                          v1, v2, v3;
  logic signed [smf_pkg::IW-1:0] base1, base2;
  logic signed [smf_pkg::IW-1:0] diff1;
  logic signed [TW:0]            t1;
  logic signed [PW-1:0]          prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    base1  <= a0;
    diff1  <= a1 - a0;
    t1     <= $signed({1'b0, t});
    base2  <= base1;
    prod2  <= PW'(diff1) * PW'(t1);
    result <= base2 + smf_pkg::IW'(prod2 >>> FRACTION_BITS);
  end

  assign done = v3;

endmodule

// ===== rtl/core/stability_margin_finder.sv =====
// ----------------------------------------------------------------------------
// stability_margin_finder
// Gain and phase margins from a Bode sweep, one sweep point per word.
// ----------------------------------------------------------------------------
// Each input word is one sweep point; the word marked last_point produces one
// result word with both margins and their valid bits, then the block starts a
// new sweep. The first 0 dB magnitude crossing and the first -180 degree phase
// crossing are each interpolated once. A point with no new crossing passes
// through the test and next states before the block takes another point; each
// crossing found on a point runs the serial divider (one quotient bit per
// cycle, FRACTION_BITS + 1 bits) and then two passes through the three-stage
// interpolator, first for the frequency and then for the margin. A last point
// then moves the result into the output register, and waits there only while
// the previous result has not yet been taken.
// ----------------------------------------------------------------------------
module stability_margin_finder #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        freq,
  input  logic signed [15:0] mag,
  input  logic signed [19:0] phase,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        gc_freq,
  output logic signed [19:0] phase_margin,
  output logic               pm_valid,
  output logic [31:0]        pc_freq,
  output logic signed [15:0] gain_margin,
  output logic               gm_valid
);

  localparam int TW = FRACTION_BITS + 1;
  localparam int DW = smf_pkg::DIV_W;
  localparam int IW = smf_pkg::IW;

  smf_pkg::state_t state, state_next;

  logic [31:0]        freq_r;
  logic signed [15:0] mag_r;
  logic signed [19:0] phase_r;
  logic               last_r;

  logic [31:0]        prev_freq;
  logic signed [15:0] prev_mag;
  logic signed [19:0] prev_phase;
  logic               have_prev;
  logic               pm_found, gm_found;
  logic               do_pm, do_gm;
  logic               sel;
  logic [31:0]        held_gc_freq, held_pc_freq;
  logic signed [19:0] held_phase_margin;
  logic signed [15:0] held_gain_margin;
  logic [TW-1:0]      t_r;

  logic               div_start, div_done;
  logic [TW-1:0]      div_quot;
  logic               ip_start, ip_done;
  logic signed [IW-1:0] ip_a0, ip_a1, ip_res;
  logic [TW-1:0]      ip_t;

  logic signed [DW-1:0] ym0, ym1, yp0, yp1, y0, y1;
  logic signed [DW:0]   dy, dy_abs;
  logic [DW-1:0]        num, den;
  logic                 cross_m, cross_p, same_freq;
  logic signed [21:0]   pm_sum;
  logic signed [19:0]   pm_sat;
  logic signed [16:0]   gm_neg;
  logic signed [15:0]   gm_sat;

  // crossing quantities and divider operands
  always_comb begin
    ym0 = DW'(prev_mag);
    ym1 = DW'(mag_r);
    yp0 = DW'(prev_phase) + DW'(smf_pkg::HALF_TURN);
    yp1 = DW'(phase_r) + DW'(smf_pkg::HALF_TURN);
    cross_m = (ym0 <= 0 && ym1 >= 0) || (ym0 >= 0 && ym1 <= 0);
    cross_p = (yp0 <= 0 && yp1 >= 0) || (yp0 >= 0 && yp1 <= 0);
    same_freq = freq_r == prev_freq;
    y0 = sel ? yp0 : ym0;
    y1 = sel ? yp1 : ym1;
    dy = (DW + 1)'(y1) - (DW + 1)'(y0);
    dy_abs = dy[DW] ? -dy : dy;
    num = y0[DW-1] ? DW'(-y0) : DW'(y0);
    den = dy_abs[DW-1:0];
  end

  // interpolator operands
  always_comb begin
    if (state == smf_pkg::S_F_START) begin
      ip_a0 = IW'(prev_freq);
      ip_a1 = IW'(freq_r);
      ip_t  = t_r;
    end else begin
      ip_a0 = sel ? IW'(prev_mag) : IW'(prev_phase);
      ip_a1 = sel ? IW'(mag_r) : IW'(phase_r);
      ip_t  = same_freq ? '0 : t_r;
    end
  end

  // margin saturation
  always_comb begin
    pm_sum = 22'(ip_res) + 22'(smf_pkg::HALF_TURN);
    if (pm_sum > 22'(smf_pkg::PHASE_MAX)) begin
      pm_sat = 20'(smf_pkg::PHASE_MAX);
    end else if (pm_sum < 22'(smf_pkg::PHASE_MIN)) begin
      pm_sat = 20'(smf_pkg::PHASE_MIN);
    end else begin
      pm_sat = pm_sum[19:0];
    end
    gm_neg = -17'(ip_res);
    if (gm_neg > 17'(smf_pkg::MAG_MAX)) begin
      gm_sat = 16'(smf_pkg::MAG_MAX);
    end else if (gm_neg < 17'(smf_pkg::MAG_MIN)) begin
      gm_sat = 16'(smf_pkg::MAG_MIN);
    end else begin
      gm_sat = gm_neg[15:0];
    end
  end

  smf_divider #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_divider (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quot (div_quot)
  );

  smf_interp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_interp (
    .clk   (clk),
    .rst   (rst),
    .start (ip_start),
    .a0    (ip_a0),
    .a1    (ip_a1),
    .t     (ip_t),
    .done  (ip_done),
    .result(ip_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    ip_start   = 1'b0;
    case (state)
      smf_pkg::S_IDLE: begin
        if (in_valid) state_next = smf_pkg::S_TEST;
      end
      smf_pkg::S_TEST: begin
        state_next = smf_pkg::S_NEXT;
      end
      smf_pkg::S_NEXT: begin
        if (do_pm || do_gm) begin
          state_next = smf_pkg::S_DIV_START;
        end else if (last_r) begin
          state_next = smf_pkg::S_FINISH;
        end else begin
          state_next = smf_pkg::S_IDLE;
        end
      end
      smf_pkg::S_DIV_START: begin
        div_start  = 1'b1;
        state_next = smf_pkg::S_DIV_WAIT;
      end
      smf_pkg::S_DIV_WAIT: begin
        if (div_done) state_next = smf_pkg::S_F_START;
      end
      smf_pkg::S_F_START: begin
        ip_start   = 1'b1;
        state_next = smf_pkg::S_F_WAIT;
      end
      smf_pkg::S_F_WAIT: begin
        if (ip_done) state_next = smf_pkg::S_Y_START;
      end
      smf_pkg::S_Y_START: begin
        ip_start   = 1'b1;
        state_next = smf_pkg::S_Y_WAIT;
      end
      smf_pkg::S_Y_WAIT: begin
        if (ip_done) state_next = smf_pkg::S_NEXT;
      end
      smf_pkg::S_FINISH: begin
        if (!out_valid || out_ready) state_next = smf_pkg::S_IDLE;
      end
      default: begin
        state_next = smf_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready = state == smf_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      pm_found  <= 1'b0;
      gm_found  <= 1'b0;
      do_pm     <= 1'b0;
      do_gm     <= 1'b0;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != smf_pkg::S_FINISH) out_valid <= 1'b0;
      case (state)
        smf_pkg::S_IDLE: begin
          if (in_valid) begin
            freq_r  <= freq;
            mag_r   <= mag;
            phase_r <= phase;
            last_r  <= last_point;
          end
        end
        smf_pkg::S_TEST: begin
          do_pm <= have_prev && !pm_found && cross_m;
          do_gm <= have_prev && !gm_found && cross_p;
        end
        smf_pkg::S_NEXT: begin
          if (do_pm) begin
            sel <= 1'b0;
          end else if (do_gm) begin
            sel <= 1'b1;
          end else begin
            prev_freq  <= freq_r;
            prev_mag   <= mag_r;
            prev_phase <= phase_r;
            have_prev  <= 1'b1;
          end
        end
        smf_pkg::S_DIV_WAIT: begin
          if (div_done) t_r <= div_quot;
        end
        smf_pkg::S_F_WAIT: begin
          if (ip_done) begin
            if (sel) begin
              held_pc_freq <= ip_res[31:0];
            end else begin
              held_gc_freq <= ip_res[31:0];
            end
          end
        end
        smf_pkg::S_Y_WAIT: begin
          if (ip_done) begin
            if (sel) begin
              held_gain_margin <= gm_sat;
              gm_found         <= 1'b1;
              do_gm            <= 1'b0;
            end else begin
              held_phase_margin <= pm_sat;
              pm_found          <= 1'b1;
              do_pm             <= 1'b0;
            end
          end
        end
        smf_pkg::S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            gc_freq      <= pm_found ? held_gc_freq : '0;
            phase_margin <= pm_found ? held_phase_margin : '0;
            pm_valid     <= pm_found;
            pc_freq      <= gm_found ? held_pc_freq : '0;
            gain_margin  <= gm_found ? held_gain_margin : '0;
            gm_valid     <= gm_found;
            have_prev    <= 1'b0;
            pm_found     <= 1'b0;
            gm_found     <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == smf_pkg::S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_fraction_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_quot <= {1'b1, {FRACTION_BITS{1'b0}}})
    else $error("interpolation fraction above one");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == smf_pkg::S_FINISH)
    else $error("result word raised outside finish");

  a_no_pm_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pm_valid |-> gc_freq == '0 && phase_margin == '0)
    else $error("phase margin fields set without a crossing");

  a_sweep_cleared: assert property (@(posedge clk) disable iff (rst)
    state == smf_pkg::S_FINISH && (!out_valid || out_ready)
      |=> !have_prev && !pm_found && !gm_found)
    else $error("sweep state not cleared after result");
`endif

endmodule
